// ===== hw/rtl/fss_pkg.sv =====
package fss_pkg;

    localparam int TEXT_DEPTH    = 128;
    localparam int PATTERN_DEPTH = 128;

    localparam int CH_W  = 8;
    localparam int POS_W = 7;

    localparam int MAX_DEPTH = (TEXT_DEPTH > PATTERN_DEPTH) ? TEXT_DEPTH : PATTERN_DEPTH;
    // lengths and search counters must hold the depth itself
    localparam int LEN_W  = $clog2(MAX_DEPTH + 1);
    localparam int TIDX_W = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int PIDX_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic wr_byte;   // store the accepted byte
        logic init;      // start a search
        logic cmp;       // compare the registered bytes
        logic push;      // move result to output and clear lengths
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_ok;     // pattern non-empty and not longer than text
        logic eq;          // registered bytes match
        logic pat_end;     // current byte is the last of the pattern
        logic last_start;  // current start is the last possible one
        logic out_full;    // output register cannot take a result
    } dp_stat_t;

endpackage

// ===== hw/rtl/fss_in_if.sv =====
interface fss_in_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [fss_pkg::CH_W-1:0]  ch;
    logic                      last;

    modport source (output valid, output op, output ch, output last, input ready);
    modport sink   (input valid, input op, input ch, input last, output ready);
endinterface

// ===== hw/rtl/fss_out_if.sv =====
interface fss_out_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [fss_pkg::POS_W-1:0] position;
    logic                      overflow;

    modport source (output valid, output found, output position, output overflow, input ready);
    modport sink   (input valid, input found, input position, input overflow, output ready);
endinterface

// ===== hw/rtl/fss_ctrl.sv =====
module fss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_op,
    input  logic               in_last,
    output logic               in_ready,
    input  fss_pkg::dp_stat_t  stat,
    output fss_pkg::ctrl_cmd_t cmd
);
    import fss_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_READ,
        ST_CMP,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign accept   = in_valid && ready_reg;
    assign in_ready = ready_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.wr_byte = accept;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && in_op == OP_TEXT && in_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = stat.init_ok ? ST_READ : ST_HOLD;
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (stat.eq && stat.pat_end)
                begin
                    state_next = ST_HOLD;
                end
                else if (!stat.eq && stat.last_start)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_HOLD:
            begin
                if (!stat.out_full)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        ready_next = (state_next == ST_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    a_ready_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> state_reg == ST_LOAD)
        else $error("ready outside load state");

    a_text_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == OP_TEXT && in_last) |=> state_reg == ST_INIT && !ready_reg)
        else $error("text end did not start search");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_byte, cmd.init, cmd.cmp, cmd.push}))
        else $error("overlapping commands");

endmodule

// ===== hw/rtl/fss_datapath.sv =====
module fss_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_op,
    input  logic [fss_pkg::CH_W-1:0]   in_ch,
    input  fss_pkg::ctrl_cmd_t         cmd,
    output fss_pkg::dp_stat_t          stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_found,
    output logic [fss_pkg::POS_W-1:0]  out_position,
    output logic                       out_overflow
);
    import fss_pkg::*;

    logic [CH_W-1:0] pat_mem  [PATTERN_DEPTH];
    logic [CH_W-1:0] text_mem [TEXT_DEPTH];
    logic [CH_W-1:0] pat_rd_reg, text_rd_reg;

    logic [LEN_W-1:0] plen_reg, tlen_reg;
    logic             drop_reg;
    logic [LEN_W-1:0] start_reg, k_reg;
    logic             res_found_reg;
    logic [LEN_W-1:0] res_pos_reg;

    logic             out_valid_reg;
    logic             out_found_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic             out_ovf_reg;

    logic [LEN_W-1:0] taddr;
    logic             pat_room, text_room;

    assign taddr     = LEN_W'(start_reg + k_reg);
    assign pat_room  = plen_reg < LEN_W'(PATTERN_DEPTH);
    assign text_room = tlen_reg < LEN_W'(TEXT_DEPTH);

    assign stat.init_ok    = (plen_reg != '0) && (plen_reg <= tlen_reg);
    assign stat.eq         = (pat_rd_reg == text_rd_reg);
    assign stat.pat_end    = (LEN_W'(k_reg + 1'b1) == plen_reg);
    assign stat.last_start = (LEN_W'(start_reg + plen_reg) >= tlen_reg);
    assign stat.out_full   = out_valid_reg && !out_ready;

    // byte stores, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte && in_op == OP_PATTERN && pat_room)
        begin
            pat_mem[plen_reg[PIDX_W-1:0]] <= in_ch;
        end
        if (cmd.wr_byte && in_op == OP_TEXT && text_room)
        begin
            text_mem[tlen_reg[TIDX_W-1:0]] <= in_ch;
        end
        pat_rd_reg  <= pat_mem[k_reg[PIDX_W-1:0]];
        text_rd_reg <= text_mem[taddr[TIDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            tlen_reg <= '0;
            drop_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            plen_reg <= '0;
            tlen_reg <= '0;
            drop_reg <= 1'b0;
        end
        else if (cmd.wr_byte)
        begin
            if (in_op == OP_PATTERN)
            begin
                if (pat_room)
                begin
                    plen_reg <= LEN_W'(plen_reg + 1'b1);
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            else
            begin
                if (text_room)
                begin
                    tlen_reg <= LEN_W'(tlen_reg + 1'b1);
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
        end
    end

    // search counters and result
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            start_reg     <= '0;
            k_reg         <= '0;
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        else if (cmd.cmp)
        begin
            if (stat.eq && stat.pat_end)
            begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= start_reg;
            end
            else if (stat.eq)
            begin
                k_reg <= LEN_W'(k_reg + 1'b1);
            end
            else if (!stat.last_start)
            begin
                start_reg <= LEN_W'(start_reg + 1'b1);
                k_reg     <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_found_reg ? POS_W'(res_pos_reg) : '0;
            out_ovf_reg   <= drop_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = out_found_reg;
    assign out_position = out_pos_reg;
    assign out_overflow = out_ovf_reg;

    a_push_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !(out_valid_reg && !out_ready))
        else $error("result pushed over a pending one");

    a_lengths_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= LEN_W'(PATTERN_DEPTH) && tlen_reg <= LEN_W'(TEXT_DEPTH))
        else $error("length beyond store depth");

    a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> plen_reg == '0 && tlen_reg == '0 && !drop_reg && out_valid_reg)
        else $error("lengths not cleared after result");

    a_window_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |-> LEN_W'(start_reg + plen_reg) <= tlen_reg && k_reg < plen_reg)
        else $error("compare window outside text");

endmodule

// ===== hw/rtl/first_substring_position.sv =====
// first_substring_position: earliest position of a pattern inside a text
// loading: one byte per cycle for pattern and text transactions when idle
// search: after the text's last byte, an init state, then a read state and
//   a compare state per byte compare (registered store reads), then a hold
//   state that posts the result once the output is free; input stalled meanwhile
// reset: lengths, overflow flag and output valid cleared; stores not cleared
module first_substring_position (
    input  logic      clk,
    input  logic      rst_n,
    fss_in_if.sink    in_ch,
    fss_out_if.source out_ch
);
    import fss_pkg::*;

    // command and status between controller and datapath
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // controller: input handshake and search sequencing
    fss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .in_last  (in_ch.last),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: byte stores, lengths, compare counters, output register
    fss_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_op        (in_ch.op),
        .in_ch        (in_ch.ch),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_found    (out_ch.found),
        .out_position (out_ch.position),
        .out_overflow (out_ch.overflow)
    );

endmodule

// ===== dv/tb_first_substring_position.sv =====
`timescale 1ns / 1ps

module tb_first_substring_position;

    import fss_pkg::*;

    // run length and pacing
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int ITEM_TARGET    = 1650;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int SETTLE_CYCLES  = 200;

    // one byte transaction waiting to be offered on the input channel
    typedef struct {
        logic              op;
        logic [CH_W-1:0]   ch;
        logic              last;
        bit                drain;   // hold this byte back until no result is outstanding
    } byte_item_t;

    // one search outcome as the output channel carries it
    typedef struct {
        logic              found;
        logic [POS_W-1:0]  position;
        logic              overflow;
    } search_result_t;

    // receiver behavior between mode changes
    typedef enum logic [1:0] {
        RX_EAGER,   // always ready
        RX_COIN,    // ready half the time
        RX_SLOW     // ready one cycle in four
    } rx_mode_t;

    logic clk;
    logic rst_n;

    fss_in_if  in_bus();
    fss_out_if out_bus();

    first_substring_position uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // search predictor: its own copy of both byte stores
    // ------------------------------------------------------------------
    logic [CH_W-1:0] pattern_bytes [PATTERN_DEPTH];
    logic [CH_W-1:0] text_bytes    [TEXT_DEPTH];
    int              pattern_fill  = 0;
    int              text_fill     = 0;
    bit              bytes_dropped = 1'b0;

    byte_item_t      pending_q [$];     // transactions not yet accepted
    search_result_t  expected_q [$];    // results predicted but not yet seen

    // takes one accepted byte; a text byte marked last closes the pair and
    // yields the earliest match position
    function automatic void absorb_byte(input byte_item_t item);
        search_result_t outcome;
        int             start;
        int             k;
        bit             hit;
        if (item.op == OP_PATTERN)
        begin
            if (pattern_fill < PATTERN_DEPTH)
            begin
                pattern_bytes[pattern_fill] = item.ch;
                pattern_fill++;
            end
            else
                bytes_dropped = 1'b1;
            return;
        end
        if (text_fill < TEXT_DEPTH)
        begin
            text_bytes[text_fill] = item.ch;
            text_fill++;
        end
        else
            bytes_dropped = 1'b1;
        if (!item.last)
            return;

        outcome.found    = 1'b0;
        outcome.position = '0;
        outcome.overflow = bytes_dropped;
        hit   = 1'b0;
        start = 0;
        // an empty pattern or one longer than the text never matches
        if (pattern_fill != 0 && pattern_fill <= text_fill)
        begin
            while (!hit && start + pattern_fill <= text_fill)
            begin
                k = 0;
                while (k < pattern_fill && text_bytes[start + k] == pattern_bytes[k])
                    k++;
                if (k == pattern_fill)
                begin
                    hit              = 1'b1;
                    outcome.found    = 1'b1;
                    outcome.position = start[POS_W-1:0];
                end
                else
                    start++;
            end
        end
        expected_q.push_back(outcome);

        // the pair is consumed, both stores start over
        pattern_fill  = 0;
        text_fill     = 0;
        bytes_dropped = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    logic [CH_W-1:0] pattern_buf [$];
    logic [CH_W-1:0] text_buf [$];
    logic [CH_W-1:0] alphabet [4];
    int              alphabet_size;
    bit              any_byte;       // draw from every nonzero byte value

    function automatic void queue_byte(input logic op, input logic [CH_W-1:0] ch,
                                       input logic last, input bit drain);
        byte_item_t item;
        item.op    = op;
        item.ch    = ch;
        item.last  = last;
        item.drain = drain;
        pending_q.push_back(item);
    endfunction

    // pattern_buf then text_buf as one pair; split_at puts an extra last
    // inside the pattern, random_lasts sets or clears last at random on each pattern byte
    function automatic void queue_pair(input int split_at, input bit random_lasts,
                                       input bit drain);
        logic mark;
        for (int i = 0; i < pattern_buf.size(); i++)
        begin
            mark = (i == pattern_buf.size() - 1) || (i == split_at);
            if (random_lasts)
                mark = 1'($urandom_range(0, 1));
            queue_byte(OP_PATTERN, pattern_buf[i], mark, drain && i == 0);
        end
        for (int i = 0; i < text_buf.size(); i++)
            queue_byte(OP_TEXT, text_buf[i], i == text_buf.size() - 1,
                       drain && i == 0 && pattern_buf.size() == 0);
    endfunction

    function automatic logic [CH_W-1:0] pick_char();
        if (any_byte)
            return CH_W'($urandom_range(1, 255));
        return alphabet[$urandom_range(0, alphabet_size - 1)];
    endfunction

    // one random pair; returns the number of transactions it adds
    function automatic int build_random_pair();
        int kind;
        int pat_len;
        int txt_len;
        int reach;
        int at;
        int split_at;
        bit random_lasts;
        kind          = $urandom_range(0, 99);
        alphabet_size = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++)
            alphabet[i] = CH_W'($urandom_range(1, 255));
        any_byte      = 1'b0;
        split_at      = -1;
        random_lasts  = 1'b0;
        pat_len       = $urandom_range(1, 6);
        txt_len       = $urandom_range(1, 40);

        if (kind < 3)
        begin
            // large pair, at times beyond one of the stores
            pat_len       = $urandom_range(90, 135);
            txt_len       = $urandom_range(100, 140);
            alphabet_size = 2;
        end
        else if (kind < 9)
        begin
            // pattern longer than the text
            pat_len = $urandom_range(2, 8);
            txt_len = $urandom_range(1, pat_len - 1);
        end
        else if (kind < 13)
            pat_len = 0;            // text with no pattern in front of it
        else if (kind < 20)
            any_byte = 1'b1;        // noise over all nonzero byte values
        else if (kind < 27)
            random_lasts = 1'b1;    // broken framing on the pattern side
        else if (kind < 36 && pat_len >= 2)
            split_at = $urandom_range(0, pat_len - 2);

        pattern_buf.delete();
        text_buf.delete();
        for (int i = 0; i < pat_len; i++)
            pattern_buf.push_back(pick_char());
        for (int i = 0; i < txt_len; i++)
            text_buf.push_back(pick_char());

        // plant the kept part of the pattern in the kept part of the text
        reach = (txt_len < TEXT_DEPTH) ? txt_len : TEXT_DEPTH;
        if (pat_len != 0 && pat_len <= reach && $urandom_range(0, 2) != 0)
        begin
            at = $urandom_range(0, reach - pat_len);
            for (int i = 0; i < pat_len; i++)
                text_buf[at + i] = pattern_buf[i];
        end

        queue_pair(split_at, random_lasts, $urandom_range(0, 24) == 0);
        return pat_len + txt_len;
    endfunction

    // ------------------------------------------------------------------
    // input driver: bursts of transactions with random gaps
    // ------------------------------------------------------------------
    bit in_taken   = 1'b0;
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            absorb_byte(pending_q[0]);
            pending_q.delete(0);
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
            in_bus.op    <= OP_PATTERN;
            in_bus.ch    <= '0;
            in_bus.last  <= 1'b0;
        end
        // a transaction on offer stays put until it is taken
        else if (!in_bus.valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_bus.valid <= 1'b0;
            end
            else if (pending_q.size() == 0 || (pending_q[0].drain && expected_q.size() != 0))
                in_bus.valid <= 1'b0;
            else
            begin
                in_bus.valid <= 1'b1;
                in_bus.op    <= pending_q[0].op;
                in_bus.ch    <= pending_q[0].ch;
                in_bus.last  <= pending_q[0].last;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output receiver: its own stall pattern plus two long hold-offs
    // ------------------------------------------------------------------
    rx_mode_t rx_mode       = RX_EAGER;
    int       mode_left     = 0;
    int       holdoff_left  = 0;
    int       holdoffs_done = 0;
    int       results_seen  = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            out_bus.ready <= 1'b0;
        else
        begin
            // long hold-off lets the block back up into its input
            if (holdoff_left == 0 && holdoffs_done < 2
                && results_seen >= ((holdoffs_done == 0) ? 8 : 120))
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoffs_done++;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left > 0)
                    mode_left--;
                else
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 128);
                end
                case (rx_mode)
                    RX_EAGER: out_bus.ready <= 1'b1;
                    RX_COIN:  out_bus.ready <= 1'($urandom_range(0, 1));
                    default:  out_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    int             mismatch_count = 0;
    search_result_t want;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none outstanding",
                                          results_seen));
            else
            begin
                want = expected_q[0];
                expected_q.delete(0);
                if (out_bus.found !== want.found)
                    report_mismatch($sformatf("result %0d found %b, expected %b",
                                              results_seen, out_bus.found, want.found));
                if (out_bus.position !== want.position)
                    report_mismatch($sformatf("result %0d position %0d, expected %0d",
                                              results_seen, out_bus.position, want.position));
                if (out_bus.overflow !== want.overflow)
                    report_mismatch($sformatf("result %0d overflow %b, expected %b",
                                              results_seen, out_bus.overflow, want.overflow));
            end
        end
    end

    // watchdog
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("** first_substring_position: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int random_items;

        rst_n = 1'b0;

        // text with no pattern loaded never matches
        queue_byte(OP_TEXT, 8'h41, 1'b1, 1'b0);
        // one-byte pattern, byte range extremes, match at the last text byte
        queue_byte(OP_PATTERN, 8'h01, 1'b1, 1'b0);
        queue_byte(OP_TEXT, 8'hFF, 1'b0, 1'b0);
        queue_byte(OP_TEXT, 8'h01, 1'b1, 1'b0);
        // last on a pattern byte keeps appending; pattern then outgrows the text
        queue_byte(OP_PATTERN, 8'hFF, 1'b1, 1'b0);
        queue_byte(OP_PATTERN, 8'h80, 1'b1, 1'b0);
        queue_byte(OP_TEXT, 8'hFF, 1'b1, 1'b0);
        // nul byte compares like any other value
        queue_byte(OP_PATTERN, 8'h00, 1'b1, 1'b0);
        queue_byte(OP_TEXT, 8'h55, 1'b0, 1'b0);
        queue_byte(OP_TEXT, 8'h00, 1'b0, 1'b0);
        queue_byte(OP_TEXT, 8'h00, 1'b1, 1'b0);
        // partial match first, full match one step later
        queue_byte(OP_PATTERN, 8'h7F, 1'b0, 1'b0);
        queue_byte(OP_PATTERN, 8'h01, 1'b1, 1'b0);
        queue_byte(OP_TEXT, 8'h7F, 1'b0, 1'b0);
        queue_byte(OP_TEXT, 8'h7F, 1'b0, 1'b0);
        queue_byte(OP_TEXT, 8'h01, 1'b1, 1'b0);
        // pattern equal to the text
        queue_byte(OP_PATTERN, 8'hAA, 1'b0, 1'b0);
        queue_byte(OP_PATTERN, 8'hBB, 1'b1, 1'b0);
        queue_byte(OP_TEXT, 8'hAA, 1'b0, 1'b0);
        queue_byte(OP_TEXT, 8'hBB, 1'b1, 1'b0);
        // pattern absent
        queue_byte(OP_PATTERN, 8'h01, 1'b1, 1'b0);
        queue_byte(OP_TEXT, 8'hFE, 1'b1, 1'b0);

        // text store overflows; the only hit sits at the highest kept index,
        // the dropped tail repeats the pattern byte
        pattern_buf.delete();
        text_buf.delete();
        pattern_buf.push_back(8'hFE);
        for (int i = 0; i < TEXT_DEPTH; i++)
            text_buf.push_back(CH_W'($urandom_range(1, 253)));
        text_buf[TEXT_DEPTH - 1] = 8'hFE;
        text_buf.push_back(8'hFE);
        text_buf.push_back(8'hFE);
        queue_pair(-1, 1'b0, 1'b1);

        // pattern store overflows; the kept part equals the whole text
        pattern_buf.delete();
        text_buf.delete();
        for (int i = 0; i <= PATTERN_DEPTH; i++)
            pattern_buf.push_back(CH_W'($urandom_range(1, 255)));
        for (int i = 0; i < PATTERN_DEPTH && i < TEXT_DEPTH; i++)
            text_buf.push_back(pattern_buf[i]);
        queue_pair(-1, 1'b0, 1'b1);

        // random pairs until the whole run reaches its item count
        random_items = pending_q.size();
        while (random_items < ITEM_TARGET)
            random_items += build_random_pair();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        // anything late or extra shows up here
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** first_substring_position: PASSED **");
        else
            $display("** first_substring_position: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/fss_pkg.sv
hw/rtl/fss_in_if.sv
hw/rtl/fss_out_if.sv
hw/rtl/fss_ctrl.sv
hw/rtl/fss_datapath.sv
hw/rtl/first_substring_position.sv
dv/tb_first_substring_position.sv
